/* rtl/core/mooi_pkg.sv */
// Shared types, constants and helpers for the outer/inner-axis mean block.
// No dependencies; every other file refers to this package by scoped names.
package mooi_pkg;

    localparam int MAX_MIDDLE = 1024;
    localparam int MidxW      = $clog2(MAX_MIDDLE);

    localparam int LenW      = 13;
    localparam int MidLenW   = 11;
    localparam int PosW      = 12;
    localparam int InvW      = 33;
    localparam int SampleW   = 32;
    localparam int AccW      = 56;
    localparam int CfgIdxW   = 2;
    localparam int CfgDataW  = 33;

    localparam int QueueDepth = 4;
    localparam int QPtrW      = $clog2(QueueDepth);

    // register indexes on the configuration port
    localparam logic [CfgIdxW-1:0] CFG_OUTER  = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_MIDDLE = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_INNER  = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_INV    = 2'd3;

    localparam logic [LenW-1:0]    LEN_CAP = 13'd4096;
    localparam logic [MidLenW-1:0] MID_CAP =
        (MAX_MIDDLE < 1024) ? MidLenW'(MAX_MIDDLE) : 11'd1024;
    localparam logic [InvW-1:0]    INV_ONE = 33'h1_0000_0000;

    typedef struct packed {
        logic [LenW-1:0]    outer_len;
        logic [MidLenW-1:0] middle_len;
        logic [LenW-1:0]    inner_len;
        logic [InvW-1:0]    inv_count;
    } t_cfg;

    // one classified sample on its way from the front to the back
    typedef struct packed {
        logic signed [SampleW-1:0] sample;
        logic [MidxW-1:0]          m;
        logic                      first;
        logic                      emit;
        logic                      last;
    } t_item;

    function automatic logic [LenW-1:0] clamp_len(input logic [LenW-1:0] v);
        logic [LenW-1:0] r;
        if (v == '0) begin
            r = LenW'(1);
        end else if (v > LEN_CAP) begin
            r = LEN_CAP;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

/* rtl/core/mean_over_outer_and_inner_axes.sv */
// A slice's mean follows its last accepted sample via the queue and the back-end pipeline.
// Throughput: one sample per cycle unless stalled, set by the single accumulator read/write.
// Output stall halts the back end; a 4-entry queue absorbs samples before o_stall rises.
// Reset (synchronous, active low) clears positions, queue and pipeline valids and loads
// lengths 1 and reciprocal 2^32; the accumulator memory is not cleared, since the
// first sample of each slice loads its entry.
module mean_over_outer_and_inner_axes (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mooi_pkg::CfgIdxW-1:0]        i_cfg_idx,
    input  logic [mooi_pkg::CfgDataW-1:0]       i_cfg_data,
    input  logic                                i_valid,
    input  logic signed [mooi_pkg::SampleW-1:0] i_sample,
    output logic                                o_stall,
    output logic                                o_valid,
    output logic signed [mooi_pkg::SampleW-1:0] o_mean,
    output logic [mooi_pkg::MidxW-1:0]          o_middle_index,
    output logic                                o_last,
    input  logic                                i_stall
);

    mooi_pkg::t_cfg  r_cfg;
    mooi_pkg::t_item front_item;
    mooi_pkg::t_item head_item;
    logic            push, pop, full, empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.outer_len  <= mooi_pkg::LenW'(1);
            r_cfg.middle_len <= mooi_pkg::MidLenW'(1);
            r_cfg.inner_len  <= mooi_pkg::LenW'(1);
            r_cfg.inv_count  <= mooi_pkg::INV_ONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mooi_pkg::CFG_OUTER:  r_cfg.outer_len  <= i_cfg_data[mooi_pkg::LenW-1:0];
                mooi_pkg::CFG_MIDDLE: r_cfg.middle_len <= i_cfg_data[mooi_pkg::MidLenW-1:0];
                mooi_pkg::CFG_INNER:  r_cfg.inner_len  <= i_cfg_data[mooi_pkg::LenW-1:0];
                mooi_pkg::CFG_INV:    r_cfg.inv_count  <= i_cfg_data[mooi_pkg::InvW-1:0];
                default:              r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_stall = full;

    mooi_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_valid),
        .i_sample (i_sample),
        .i_full   (full),
        .o_push   (push),
        .o_item   (front_item)
    );

    mooi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head_item)
    );

    mooi_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_inv          (r_cfg.inv_count),
        .i_empty        (empty),
        .i_head         (head_item),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .o_mean         (o_mean),
        .o_middle_index (o_middle_index),
        .o_last         (o_last),
        .i_stall        (i_stall)
    );

endmodule

/* rtl/core/mooi_front.sv */
// Front end: accepts samples, tracks outer/middle/inner positions and tags
// each sample as slice start, slice end and final middle index. Uses mooi_pkg.
module mooi_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mooi_pkg::t_cfg                     i_cfg,
    input  logic                               i_valid,
    input  logic signed [mooi_pkg::SampleW-1:0] i_sample,
    input  logic                               i_full,
    output logic                               o_push,
    output mooi_pkg::t_item                    o_item
);

    logic [mooi_pkg::PosW-1:0]  r_outer_pos, n_outer_pos;
    logic [mooi_pkg::MidxW-1:0] r_middle_pos, n_middle_pos;
    logic [mooi_pkg::PosW-1:0]  r_inner_pos, n_inner_pos;

    logic [mooi_pkg::LenW-1:0]    n_out_len;
    logic [mooi_pkg::LenW-1:0]    n_in_len;
    logic [mooi_pkg::MidLenW-1:0] n_mid_len;
    logic inner_end, outer_end, middle_end;

    always_comb begin
        n_out_len = mooi_pkg::clamp_len(i_cfg.outer_len);
        n_in_len  = mooi_pkg::clamp_len(i_cfg.inner_len);
        if (i_cfg.middle_len == '0) begin
            n_mid_len = mooi_pkg::MidLenW'(1);
        end else if (i_cfg.middle_len > mooi_pkg::MID_CAP) begin
            n_mid_len = mooi_pkg::MID_CAP;
        end else begin
            n_mid_len = i_cfg.middle_len;
        end

        // a position at or past a shortened length counts as the final one
        inner_end  = (mooi_pkg::LenW'(r_inner_pos) + mooi_pkg::LenW'(1)) >= n_in_len;
        outer_end  = (mooi_pkg::LenW'(r_outer_pos) + mooi_pkg::LenW'(1)) >= n_out_len;
        middle_end = (mooi_pkg::MidLenW'(r_middle_pos) + mooi_pkg::MidLenW'(1)) >= n_mid_len;

        o_push = i_valid && !i_full;

        o_item.sample = i_sample;
        o_item.m      = r_middle_pos;
        o_item.first  = (r_outer_pos == '0) && (r_inner_pos == '0);
        o_item.emit   = inner_end && outer_end;
        o_item.last   = middle_end;

        n_outer_pos  = r_outer_pos;
        n_middle_pos = r_middle_pos;
        n_inner_pos  = r_inner_pos;
        if (!inner_end) begin
            n_inner_pos = r_inner_pos + mooi_pkg::PosW'(1);
        end else begin
            n_inner_pos = '0;
            if (!middle_end) begin
                n_middle_pos = r_middle_pos + mooi_pkg::MidxW'(1);
            end else begin
                n_middle_pos = '0;
                n_outer_pos  = outer_end ? '0 : r_outer_pos + mooi_pkg::PosW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outer_pos  <= '0;
            r_middle_pos <= '0;
            r_inner_pos  <= '0;
        end else if (o_push) begin
            r_outer_pos  <= n_outer_pos;
            r_middle_pos <= n_middle_pos;
            r_inner_pos  <= n_inner_pos;
        end
    end

endmodule

/* rtl/core/mooi_queue.sv */
// Short FIFO of classified samples between the front end and the back end.
// Uses mooi_pkg for the item type and depth.
module mooi_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mooi_pkg::t_item i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output mooi_pkg::t_item o_head
);

    mooi_pkg::t_item               r_slot [mooi_pkg::QueueDepth];
    logic [mooi_pkg::QPtrW-1:0]    r_wp;
    logic [mooi_pkg::QPtrW-1:0]    r_rp;
    logic [mooi_pkg::QPtrW:0]      r_cnt;
    logic                          do_push, do_pop;

    always_comb begin
        o_full  = r_cnt == (mooi_pkg::QPtrW+1)'(mooi_pkg::QueueDepth);
        o_empty = r_cnt == '0;
        o_head  = r_slot[r_rp];
        do_push = i_push && !o_full;
        do_pop  = i_pop && !o_empty;
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + mooi_pkg::QPtrW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + mooi_pkg::QPtrW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + (mooi_pkg::QPtrW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (mooi_pkg::QPtrW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* rtl/core/mooi_back.sv */
// Back end: accumulator memory read-modify-write with forwarding, then the
// split 56x32 reciprocal multiply, floor/saturate and the output register.
// Uses mooi_pkg.
module mooi_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [mooi_pkg::InvW-1:0]           i_inv,
    input  logic                                i_empty,
    input  mooi_pkg::t_item                     i_head,
    output logic                                o_pop,
    output logic                                o_valid,
    output logic signed [mooi_pkg::SampleW-1:0] o_mean,
    output logic [mooi_pkg::MidxW-1:0]          o_middle_index,
    output logic                                o_last,
    input  logic                                i_stall
);

    localparam int HiW = mooi_pkg::AccW - 32;

    logic [mooi_pkg::AccW-1:0] r_acc_mem [mooi_pkg::MAX_MIDDLE];
    logic [mooi_pkg::AccW-1:0] r_rd;

    // stage 1: item plus accumulator read
    logic                      r_s1_valid;
    mooi_pkg::t_item           r_s1;
    // stage 2: updated sum, also the forward source for the next item
    logic                      r_s2_emit;
    logic                      r_wr_ok;
    logic [mooi_pkg::AccW-1:0] r_s2_sum;
    logic [mooi_pkg::MidxW-1:0] r_s2_m;
    logic                      r_s2_last;
    // stage 3: sign and magnitude halves
    logic                      r_s3_valid;
    logic                      r_s3_neg;
    logic [HiW-1:0]            r_s3_hi;
    logic [31:0]               r_s3_lo;
    logic [mooi_pkg::MidxW-1:0] r_s3_m;
    logic                      r_s3_last;
    // stage 4: partial products
    logic                      r_s4_valid;
    logic                      r_s4_neg;
    logic [mooi_pkg::AccW-1:0] r_s4_hi;
    logic [63:0]               r_s4_lo;
    logic [mooi_pkg::MidxW-1:0] r_s4_m;
    logic                      r_s4_last;
    // stage 5: floored magnitude of the quotient
    logic                      r_s5_valid;
    logic                      r_s5_neg;
    logic [mooi_pkg::AccW:0]   r_s5_q;
    logic [mooi_pkg::MidxW-1:0] r_s5_m;
    logic                      r_s5_last;
    // output register
    logic                      r_out_valid;
    logic [31:0]               r_out_mean;
    logic [mooi_pkg::MidxW-1:0] r_out_m;
    logic                      r_out_last;

    logic                      advance;
    logic                      fwd;
    logic [mooi_pkg::AccW-1:0] base;
    logic [mooi_pkg::AccW-1:0] n_sum;
    logic [mooi_pkg::AccW-1:0] n_mag;
    logic                      inv_full;
    logic [31:0]               inv_lo;
    logic [63:0]               n_prod_lo;
    logic [mooi_pkg::AccW-1:0] n_prod_hi;
    logic [mooi_pkg::AccW:0]   n_q;
    logic [31:0]               n_mean;

    always_comb begin
        advance = !r_out_valid || !i_stall;
        o_pop   = advance && !i_empty;

        // the previous write lands in memory at the edge that reads this item
        fwd   = r_wr_ok && (r_s2_m == r_s1.m);
        base  = r_s1.first ? '0 : (fwd ? r_s2_sum : r_rd);
        n_sum = base + {{(mooi_pkg::AccW-mooi_pkg::SampleW){r_s1.sample[31]}}, r_s1.sample};

        n_mag = r_s2_sum[mooi_pkg::AccW-1] ? (~r_s2_sum + mooi_pkg::AccW'(1)) : r_s2_sum;

        inv_full = i_inv[32];
        inv_lo   = i_inv[31:0];
        if (inv_full) begin
            n_prod_lo = {r_s3_lo, 32'd0};
            n_prod_hi = {r_s3_hi, 32'd0};
        end else begin
            n_prod_lo = 64'(r_s3_lo) * 64'(inv_lo);
            n_prod_hi = mooi_pkg::AccW'(r_s3_hi) * mooi_pkg::AccW'(inv_lo);
        end

        // round toward minus infinity: bump the magnitude of a negative inexact result
        n_q = {1'b0, r_s4_hi} + (mooi_pkg::AccW+1)'(r_s4_lo[63:32])
            + (mooi_pkg::AccW+1)'(r_s4_neg && (r_s4_lo[31:0] != '0));

        if (r_s5_neg) begin
            n_mean = (r_s5_q >= (mooi_pkg::AccW+1)'(33'h0_8000_0000))
                   ? 32'h8000_0000 : (~r_s5_q[31:0] + 32'd1);
        end else begin
            n_mean = (r_s5_q > (mooi_pkg::AccW+1)'(32'h7FFF_FFFF))
                   ? 32'h7FFF_FFFF : r_s5_q[31:0];
        end

        o_valid        = r_out_valid;
        o_mean         = r_out_mean;
        o_middle_index = r_out_m;
        o_last         = r_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd <= r_acc_mem[i_head.m];
        end
        if (advance && r_s1_valid) begin
            r_acc_mem[r_s1.m] <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_emit   <= 1'b0;
            r_wr_ok     <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_s5_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid  <= o_pop;
            r_s2_emit   <= r_s1_valid && r_s1.emit;
            r_wr_ok     <= r_wr_ok || r_s1_valid;
            r_s3_valid  <= r_s2_emit;
            r_s4_valid  <= r_s3_valid;
            r_s5_valid  <= r_s4_valid;
            r_out_valid <= r_s5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1 <= i_head;
            // hold the last written sum for forwarding across bubbles
            if (r_s1_valid) begin
                r_s2_sum  <= n_sum;
                r_s2_m    <= r_s1.m;
                r_s2_last <= r_s1.last;
            end
            r_s3_neg   <= r_s2_sum[mooi_pkg::AccW-1];
            r_s3_hi    <= n_mag[mooi_pkg::AccW-1:32];
            r_s3_lo    <= n_mag[31:0];
            r_s3_m     <= r_s2_m;
            r_s3_last  <= r_s2_last;
            r_s4_neg   <= r_s3_neg;
            r_s4_hi    <= n_prod_hi;
            r_s4_lo    <= n_prod_lo;
            r_s4_m     <= r_s3_m;
            r_s4_last  <= r_s3_last;
            r_s5_neg   <= r_s4_neg;
            r_s5_q     <= n_q;
            r_s5_m     <= r_s4_m;
            r_s5_last  <= r_s4_last;
            r_out_mean <= n_mean;
            r_out_m    <= r_s5_m;
            r_out_last <= r_s5_last;
        end
    end

endmodule

/* rtl/core/mooi_checker.sv */
// Port-level checker for mean_over_outer_and_inner_axes, bound to the top level.
// Uses mooi_pkg for widths.
module mooi_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_stall,
    input logic                                o_valid,
    input logic signed [mooi_pkg::SampleW-1:0] o_mean,
    input logic [mooi_pkg::MidxW-1:0]          o_middle_index,
    input logic                                o_last,
    input logic                                i_stall
);

    // samples accepted minus means delivered
    logic [39:0] r_bal;
    logic        in_acc, out_acc;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bal <= '0;
        end else begin
            case ({in_acc, out_acc})
                2'b10:   r_bal <= r_bal + 40'd1;
                2'b01:   r_bal <= r_bal - 40'd1;
                default: r_bal <= r_bal;
            endcase
        end
    end

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_mean)
                               && $stable(o_middle_index) && $stable(o_last))
        else $error("stalled result changed");

    a_no_invented_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_bal != '0)
        else $error("result without a pending sample");

    a_top_index_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_middle_index == mooi_pkg::MidxW'(mooi_pkg::MAX_MIDDLE - 1)) |-> o_last)
        else $error("top middle index not flagged last");

endmodule

bind mean_over_outer_and_inner_axes mooi_checker u_mooi_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .o_mean         (o_mean),
    .o_middle_index (o_middle_index),
    .o_last         (o_last),
    .i_stall        (i_stall)
);

/* dv/tb.sv */
// Testbench for mean_over_outer_and_inner_axes: streams tensors through the block, predicts
// every slice mean in SystemVerilog and checks each one against the output stream.
// Depends on rtl/core/mooi_pkg.sv and the block's RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LEN_LIMIT = 4096;
    localparam int unsigned MID_LIMIT =
        (mooi_pkg::MAX_MIDDLE < 1024) ? mooi_pkg::MAX_MIDDLE : 1024;
    localparam logic [32:0] INV_FULL = 33'h1_0000_0000;
    localparam logic signed [95:0] MEAN_MAX = 96'sd2147483647;
    localparam logic signed [95:0] MEAN_MIN = -96'sd2147483648;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEM_TARGET = 1900;

    typedef struct packed {
        logic signed [mooi_pkg::SampleW-1:0] mean;
        logic [mooi_pkg::MidxW-1:0]          midx;
        logic                                last;
    } t_slice_mean;

    typedef enum {STALL_NONE, STALL_COIN, STALL_HEAVY} t_stall_mode;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [mooi_pkg::CfgIdxW-1:0] cfg_idx = '0;
    logic [mooi_pkg::CfgDataW-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic signed [mooi_pkg::SampleW-1:0] in_sample = '0;
    logic dut_stall;
    logic out_valid;
    logic signed [mooi_pkg::SampleW-1:0] out_mean;
    logic [mooi_pkg::MidxW-1:0] out_midx;
    logic out_last;
    logic out_stall = 1'b0;

    // requests waiting for the driver, and slice means waiting for the output
    logic signed [mooi_pkg::SampleW-1:0] sample_queue[$];
    t_slice_mean expected_means[$];
    int n_enqueued = 0;
    int n_accepted = 0;
    int n_fail = 0;
    bit steady = 1'b0;
    int hold_req = 0;

    // predictor copy of the registers and of the stream position
    logic [12:0] reg_outer = 13'd1;
    logic [10:0] reg_middle = 11'd1;
    logic [12:0] reg_inner = 13'd1;
    logic [32:0] reg_inv = INV_FULL;
    int unsigned at_outer = 0;
    int unsigned at_middle = 0;
    int unsigned at_inner = 0;
    logic signed [55:0] slice_sum[mooi_pkg::MAX_MIDDLE];

    mean_over_outer_and_inner_axes uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_valid       (in_valid),
        .i_sample      (in_sample),
        .o_stall       (dut_stall),
        .o_valid       (out_valid),
        .o_mean        (out_mean),
        .o_middle_index(out_midx),
        .o_last        (out_last),
        .i_stall       (out_stall)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned span(input int unsigned v, input int unsigned cap);
        if (v == 0) begin
            return 1;
        end
        return (v > cap) ? cap : v;
    endfunction

    function automatic int unsigned tensor_size();
        return span(reg_outer, LEN_LIMIT) * span(reg_middle, MID_LIMIT) *
               span(reg_inner, LEN_LIMIT);
    endfunction

    function automatic logic [32:0] recip(input longint unsigned count);
        return 33'((64'd1 << 32) / count);
    endfunction

    // floor(sum * inv / 2^32), saturated to 32 bits
    function automatic logic signed [31:0] mean_of(input logic signed [55:0] sum,
                                                   input logic [32:0] inv);
        logic signed [95:0] prod;
        logic signed [95:0] wide_inv;
        logic signed [95:0] q;
        prod = sum;
        wide_inv = {63'd0, inv};
        prod = prod * wide_inv;
        q = prod >>> 32;
        if (q > MEAN_MAX) begin
            return 32'h7FFF_FFFF;
        end
        if (q < MEAN_MIN) begin
            return 32'h8000_0000;
        end
        return q[31:0];
    endfunction

    function automatic void predict_mean(input logic signed [31:0] s);
        int unsigned n_o, n_m, n_i, m;
        logic [32:0] inv;
        logic end_i, end_o, end_m;
        t_slice_mean r;
        n_o = span(reg_outer, LEN_LIMIT);
        n_m = span(reg_middle, MID_LIMIT);
        n_i = span(reg_inner, LEN_LIMIT);
        inv = (reg_inv > INV_FULL) ? INV_FULL : reg_inv;
        m = (at_middle >= mooi_pkg::MAX_MIDDLE) ? mooi_pkg::MAX_MIDDLE - 1 : at_middle;
        // first sample of a slice loads, the rest accumulate
        if (at_outer == 0 && at_inner == 0) begin
            slice_sum[m] = s;
        end else begin
            slice_sum[m] = slice_sum[m] + s;
        end
        end_i = (at_inner + 1 >= n_i);
        end_o = (at_outer + 1 >= n_o);
        end_m = (m + 1 >= n_m);
        if (end_i && end_o) begin
            r.mean = mean_of(slice_sum[m], inv);
            r.midx = m[mooi_pkg::MidxW-1:0];
            r.last = end_m;
            expected_means.push_back(r);
        end
        if (!end_i) begin
            at_inner = at_inner + 1;
        end else begin
            at_inner = 0;
            if (!end_m) begin
                at_middle = m + 1;
            end else begin
                at_middle = 0;
                at_outer = end_o ? 0 : at_outer + 1;
            end
        end
    endfunction

    function automatic void push_sample(input logic signed [31:0] s);
        predict_mean(s);
        sample_queue.push_back(s);
        n_enqueued++;
    endfunction

    function automatic logic signed [31:0] rand_sample();
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0: v = 32'h7FFF_FFFF;
            1: v = 32'h8000_0000;
            2: begin
                v = $urandom_range(0, 512);
                v = v - 32'sd256;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic int unsigned pick_len();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return $urandom_range(5, 12);
            default: return $urandom_range(1, 4);
        endcase
    endfunction

    task automatic write_reg(input logic [mooi_pkg::CfgIdxW-1:0] idx,
                             input logic [32:0] data);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            mooi_pkg::CFG_OUTER:  reg_outer = data[12:0];
            mooi_pkg::CFG_MIDDLE: reg_middle = data[10:0];
            mooi_pkg::CFG_INNER:  reg_inner = data[12:0];
            mooi_pkg::CFG_INV:    reg_inv = data;
            default: ;
        endcase
    endtask

    task automatic write_all(input int unsigned o, input int unsigned mi,
                             input int unsigned in_len, input logic [32:0] inv);
        write_reg(mooi_pkg::CFG_OUTER, 33'(o));
        write_reg(mooi_pkg::CFG_MIDDLE, 33'(mi));
        write_reg(mooi_pkg::CFG_INNER, 33'(in_len));
        write_reg(mooi_pkg::CFG_INV, inv);
    endtask

    // wait until every request is taken and every mean has come out
    task automatic settle();
        while (n_accepted != n_enqueued || expected_means.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic big_phase(input int unsigned o, input int unsigned mi,
                             input int unsigned in_len, input logic [32:0] inv);
        int unsigned count;
        settle();
        write_all(o, mi, in_len, inv);
        count = tensor_size();
        repeat (count) push_sample(rand_sample());
    endtask

    // driver: bursts of requests separated by random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !dut_stall) begin
                n_accepted++;
            end
            if (!in_valid || !dut_stall) begin
                if (gap_left != 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (sample_queue.size() != 0) begin
                    in_valid <= 1'b1;
                    in_sample <= sample_queue.pop_front();
                    if (burst_left != 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = (steady || $urandom_range(0, 1) == 0)
                                 ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern of its own, plus a long hold-off on request
    int hold_seen = 0;
    int hold_left = 0;
    int pat_left = 0;
    t_stall_mode pat_mode = STALL_NONE;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            if (pat_left == 0) begin
                pat_mode = t_stall_mode'($urandom_range(0, 2));
                pat_left = $urandom_range(10, 60);
            end
            pat_left--;
            case (pat_mode)
                STALL_COIN:  out_stall <= ($urandom_range(0, 1) == 1);
                STALL_HEAVY: out_stall <= (pat_left % 4 != 0);
                default:     out_stall <= 1'b0;
            endcase
        end
    end

    always @(posedge i_clk) begin : check_means
        t_slice_mean got;
        t_slice_mean want;
        if (i_rst_n && out_valid && !out_stall) begin
            got.mean = out_mean;
            got.midx = out_midx;
            got.last = out_last;
            if (expected_means.size() == 0) begin
                if (n_fail < 10) begin
                    $display("unexpected mean %0d index %0d last %0b",
                             got.mean, got.midx, got.last);
                end
                n_fail++;
            end else begin
                want = expected_means.pop_front();
                if (got.mean !== want.mean || got.midx !== want.midx ||
                    got.last !== want.last) begin
                    if (n_fail < 10) begin
                        $display("mismatch: expected %0d index %0d last %0b, got %0d %0d %0b",
                                 want.mean, want.midx, want.last,
                                 got.mean, got.midx, got.last);
                    end
                    n_fail++;
                end
            end
        end
    end

    int quiet = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && !dut_stall) || (out_valid && !out_stall) || cfg_we) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("timeout: %0d means outstanding", expected_means.size());
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    initial begin
        int unsigned o, mi, in_len, p, tensors, phase;
        logic [32:0] inv;
        phase = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // registers at reset: every sample is its own mean
        push_sample(32'h7FFF_FFFF);
        push_sample(32'h8000_0000);
        push_sample(32'h0000_0000);
        push_sample(32'hFFFF_FFFF);
        push_sample(32'h0000_0001);

        // zero lengths act as one, oversized reciprocal acts as 2^32
        settle();
        write_all(0, 0, 0, 33'h1_FFFF_FFFF);
        push_sample(32'h5A5A_A5A5);
        push_sample(32'hA5A5_5A5A);

        // means beyond the 32-bit range saturate both ways
        settle();
        write_all(2, 1, 1, INV_FULL);
        push_sample(32'h7FFF_FFFF);
        push_sample(32'h7FFF_FFFF);
        push_sample(32'h8000_0000);
        push_sample(32'h8000_0000);

        // floor rounding of negative means
        settle();
        write_all(1, 2, 3, recip(3));
        push_sample(-32'sd1);
        push_sample(32'sd0);
        push_sample(32'sd0);
        push_sample(32'sd1);
        push_sample(32'sd1);
        push_sample(-32'sd7);

        // shrink the inner axis while inside a slice; positions stay where they are
        settle();
        write_all(2, 2, 3, recip(6));
        repeat (4) push_sample(rand_sample());
        settle();
        write_reg(mooi_pkg::CFG_INNER, 33'd2);
        while (at_outer != 0 || at_middle != 0 || at_inner != 0) begin
            push_sample(rand_sample());
        end

        // oversized outer length acts as 4096; close the slice by shortening the axis
        settle();
        write_all(4097, 1, 1, INV_FULL);
        repeat (3) push_sample(rand_sample());
        settle();
        write_reg(mooi_pkg::CFG_OUTER, 33'd2);
        push_sample(rand_sample());

        // same for the inner axis
        settle();
        write_all(1, 1, 4097, INV_FULL);
        repeat (3) push_sample(rand_sample());
        settle();
        write_reg(mooi_pkg::CFG_INNER, 33'd2);
        push_sample(rand_sample());

        while (n_enqueued < ITEM_TARGET) begin
            phase++;
            case (phase)
                2: begin
                    // long receiver hold-off while the sender keeps offering
                    settle();
                    write_all(1, 8, 1, INV_FULL);
                    steady = 1'b1;
                    hold_req++;
                    repeat (80) push_sample(rand_sample());
                    settle();
                    steady = 1'b0;
                end
                5: big_phase(1, 2047, 1, INV_FULL);
                default: begin
                    settle();
                    o = pick_len();
                    in_len = pick_len();
                    case ($urandom_range(0, 9))
                        0: mi = 0;
                        1: mi = $urandom_range(9, 24);
                        default: mi = $urandom_range(1, 8);
                    endcase
                    if (span(o, LEN_LIMIT) * span(mi, MID_LIMIT) *
                        span(in_len, LEN_LIMIT) > 256) begin
                        in_len = 1;
                        mi = $urandom_range(1, 8);
                    end
                    case ($urandom_range(0, 7))
                        0: inv = '0;
                        1: inv = {1'b1, 32'($urandom)};
                        2: inv = {1'b0, 32'($urandom)};
                        default: inv = recip(span(o, LEN_LIMIT) * span(in_len, LEN_LIMIT)) +
                                       33'($urandom_range(0, 2));
                    endcase
                    write_all(o, mi, in_len, inv);
                    p = tensor_size();
                    tensors = $urandom_range(1, 1 + 120 / p);
                    steady = ($urandom_range(0, 3) == 0);
                    repeat (tensors * p) push_sample(rand_sample());
                end
            endcase
        end

        settle();
        repeat (8) @(posedge i_clk);
        if (n_fail == 0 && expected_means.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule
